// ----- design/array_element_dedup_unit_assert.svh -----
// Assertion macros shared by the array element dedup RTL.
`ifndef ARRAY_ELEMENT_DEDUP_UNIT_ASSERT_SVH
`define ARRAY_ELEMENT_DEDUP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ADU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/adu_pkg.sv -----
// Types and constants of the array element dedup unit.
`timescale 1ns / 1ps
package adu_pkg;

    localparam int unsigned VALUE_W      = 64;
    localparam int unsigned LEN_W        = 16;
    localparam int unsigned IN_TDATA_W   = 64;
    localparam int unsigned IN_TUSER_W   = 2;
    localparam int unsigned OUT_FIELDS_W = VALUE_W + LEN_W + 1;
    localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int unsigned OUT_TUSER_W  = 2;

    // tuser bit positions
    localparam int unsigned IN_NULL_BIT   = 0;
    localparam int unsigned IN_EMPTY_BIT  = 1;
    localparam int unsigned OUT_KEPT_BIT  = 0;
    localparam int unsigned OUT_NULL_BIT  = 1;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_DECIDE = 2'b10
    } state_t;

    typedef struct packed {
        logic probe;  // register compare result against the probe value
        logic shift;  // take the neighbor's value and valid bit
        logic clear;  // drop the valid bit
    } cell_ctrl_t;

endpackage

// ----- design/array_element_dedup_unit.sv -----
// Top level of the streaming per-array distinct filter.
`timescale 1ns / 1ps
// Usage:
//   Slave channel (s_*) takes one array element per transaction: the value in
//   s_tdata, the null and empty-array flags in s_tuser, end of array on s_tlast.
//   Master channel (m_*) returns exactly one result transaction per input:
//   value and running length in m_tdata, kept/null flags in m_tuser, and
//   m_tlast when the result array ends (last element or empty-array marker).
//   Each item passes through a compare step and a decision step: at the
//   accepting edge every set cell compares its stored value against the input
//   and registers a match flag; in the decision state the OR of those flags
//   decides keep/drop, the output register loads and a new value shifts into
//   the cell row. s_tready is high only between items, so the block takes no
//   new item before it is through with the last one, and m_tvalid rises when
//   the output register loads.
//   When the set is full, unmatched values are kept without being stored and
//   set_overflow stays high until the array ends.
//   Reset clears all valid bits, the count and the overflow flag; no clearing
//   pass is needed. If the receiver stalls with a result pending, the block
//   takes one more item, holds it in the decision cycle and keeps s_tready low
//   until the output register frees up.
`include "array_element_dedup_unit_assert.svh"
module array_element_dedup_unit #(
    parameter int unsigned SET_CAPACITY     = 64,
    parameter int unsigned ELEMENT_WIDTH    = 64,
    parameter int unsigned MAX_ARRAY_LENGTH = 65535
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [63:0] element_value
    input  logic [adu_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [0] element_is_null, [1] empty_array
    input  logic [adu_pkg::IN_TUSER_W-1:0]      s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [63:0] value_out, [79:64] result_length, [80] set_overflow, [87:81] zero
    output logic [adu_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // [0] kept, [1] null_out
    output logic [adu_pkg::OUT_TUSER_W-1:0]     m_tuser,
    output logic                                m_tlast
);

    localparam logic [adu_pkg::LEN_W-1:0] LEN_MAX = MAX_ARRAY_LENGTH[adu_pkg::LEN_W-1:0];

    adu_pkg::state_t state_reg, state_next;

    // Item held while the decision is made
    logic [ELEMENT_WIDTH-1:0] item_value_reg;
    logic                     item_null_reg;
    logic                     item_last_reg;
    logic                     item_empty_reg;

    // Per-array state
    logic [adu_pkg::LEN_W-1:0] kept_count_reg, kept_count_next;
    logic                      overflow_reg, overflow_next;

    // Output register
    logic                          m_valid_reg;
    logic [adu_pkg::VALUE_W-1:0]   m_value_reg;
    logic [adu_pkg::LEN_W-1:0]     m_len_reg;
    logic                          m_ovf_reg;
    logic                          m_kept_reg;
    logic                          m_null_reg;
    logic                          m_last_reg;

    adu_pkg::cell_ctrl_t      cell_ctrl;
    logic [ELEMENT_WIDTH-1:0] probe_value;
    logic                     hit_any;
    logic                     set_full;
    logic [SET_CAPACITY-1:0]  valid_vec;

    logic                        accept;
    logic                        out_free;
    logic                        load;
    logic                        is_new;
    logic                        kept;
    logic                        array_end;
    logic                        store;
    logic [adu_pkg::VALUE_W-1:0] value_wide;

    assign s_tready = (state_reg == adu_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign load     = (state_reg == adu_pkg::ST_DECIDE) && out_free;

    // Drop value bits above the element width before comparing
    assign probe_value = s_tdata[ELEMENT_WIDTH-1:0];

    // Keep/drop decision from the registered cell matches
    assign is_new    = !item_empty_reg && !item_null_reg && !hit_any;
    assign kept      = !item_empty_reg && (item_null_reg || !hit_any);
    assign array_end = item_empty_reg || item_last_reg;
    assign store     = is_new && !set_full;

    always_comb begin
        value_wide = '0;
        value_wide[ELEMENT_WIDTH-1:0] = item_value_reg;
    end

    always_comb begin
        kept_count_next = kept_count_reg;
        if (kept && (kept_count_reg < LEN_MAX)) begin
            kept_count_next = kept_count_reg + 1'b1;
        end
        overflow_next = overflow_reg || (is_new && set_full);
    end

    // Probe on accept; shift in new values and clear at array end on load
    always_comb begin
        cell_ctrl.probe = accept;
        cell_ctrl.shift = load && store;
        cell_ctrl.clear = load && array_end;
    end

    adu_cell_chain #(
        .SET_CAPACITY (SET_CAPACITY),
        .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (cell_ctrl),
        .probe_value (probe_value),
        .insert_value(item_value_reg),
        .hit_any     (hit_any),
        .full        (set_full),
        .valid_vec   (valid_vec)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            adu_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = adu_pkg::ST_DECIDE;
                end
            end
            adu_pkg::ST_DECIDE: begin
                if (out_free) begin
                    state_next = adu_pkg::ST_IDLE;
                end
            end
            default: state_next = adu_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= adu_pkg::ST_IDLE;
            kept_count_reg <= '0;
            overflow_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                // Clear per-array state once the array has been reported
                kept_count_reg <= array_end ? '0 : kept_count_next;
                overflow_reg   <= array_end ? 1'b0 : overflow_next;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture item on accept, result on load
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_value_reg <= s_tdata[ELEMENT_WIDTH-1:0];
            item_null_reg  <= s_tuser[adu_pkg::IN_NULL_BIT];
            item_last_reg  <= s_tlast;
            item_empty_reg <= s_tuser[adu_pkg::IN_EMPTY_BIT];
        end
        if (load) begin
            m_value_reg <= is_new ? value_wide : '0;
            m_len_reg   <= kept_count_next;
            m_ovf_reg   <= overflow_next;
            m_kept_reg  <= kept;
            m_null_reg  <= kept && item_null_reg;
            m_last_reg  <= array_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{adu_pkg::OUT_PAD_W{1'b0}}, m_ovf_reg, m_len_reg, m_value_reg};
    assign m_tlast  = m_last_reg;

    always_comb begin
        m_tuser = '0;
        m_tuser[adu_pkg::OUT_KEPT_BIT] = m_kept_reg;
        m_tuser[adu_pkg::OUT_NULL_BIT] = m_null_reg;
    end

    // Every accepted transaction moves straight to the decision cycle
    `ADU_ASSERT_NEXT(a_accept_decide, aclk, aresetn, accept,
        state_reg == adu_pkg::ST_DECIDE, "accept did not enter decision")
    // Valid bits fill the row from cell zero without gaps
    `ADU_ASSERT_NOW(a_valid_prefix, aclk, aresetn, 1'b1,
        ((valid_vec + 1'b1) & valid_vec) == '0, "cell valid bits not a prefix")
    // Overflow only after the whole row has been filled
    `ADU_ASSERT_NOW(a_ovf_full, aclk, aresetn, overflow_reg,
        set_full, "overflow raised with free cells")
    // Array end leaves the set, count and overflow cleared
    `ADU_ASSERT_NEXT(a_end_clear, aclk, aresetn, load && array_end,
        valid_vec == '0 && kept_count_reg == '0 && !overflow_reg,
        "array state not cleared at end")

endmodule

// ----- design/adu_cell.sv -----
// One set cell: a stored value, its valid bit and a registered match flag.
`timescale 1ns / 1ps
module adu_cell #(
    parameter int unsigned ELEMENT_WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  adu_pkg::cell_ctrl_t      ctrl,
    input  logic [ELEMENT_WIDTH-1:0] probe_value,
    input  logic [ELEMENT_WIDTH-1:0] prev_value,
    input  logic                     prev_valid,
    output logic [ELEMENT_WIDTH-1:0] value,
    output logic                     valid,
    output logic                     hit
);

    logic [ELEMENT_WIDTH-1:0] value_reg;
    logic                     valid_reg;
    logic                     hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift) begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            value_reg <= prev_value;
        end
        if (ctrl.probe) begin
            hit_reg <= valid_reg && (value_reg == probe_value);
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule

// ----- design/adu_cell_chain.sv -----
// Row of set cells; new values enter at cell zero and shift down the row.
`timescale 1ns / 1ps
module adu_cell_chain #(
    parameter int unsigned SET_CAPACITY  = 64,
    parameter int unsigned ELEMENT_WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  adu_pkg::cell_ctrl_t      ctrl,
    input  logic [ELEMENT_WIDTH-1:0] probe_value,
    input  logic [ELEMENT_WIDTH-1:0] insert_value,
    output logic                     hit_any,
    output logic                     full,
    output logic [SET_CAPACITY-1:0]  valid_vec
);

    logic [ELEMENT_WIDTH-1:0] link_value [SET_CAPACITY+1];
    logic [SET_CAPACITY:0]    link_valid;
    logic [SET_CAPACITY-1:0]  hit_vec;

    assign link_value[0] = insert_value;
    assign link_valid[0] = 1'b1;

    for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
        adu_cell #(
            .ELEMENT_WIDTH(ELEMENT_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .probe_value(probe_value),
            .prev_value (link_value[i]),
            .prev_valid (link_valid[i]),
            .value      (link_value[i+1]),
            .valid      (link_valid[i+1]),
            .hit        (hit_vec[i])
        );
    end

    assign hit_any   = |hit_vec;
    assign valid_vec = link_valid[SET_CAPACITY:1];
    assign full      = link_valid[SET_CAPACITY];

endmodule
